>>> hdl/assert_macros.svh
// assert_macros.svh: assertion helpers for the k-means block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> hdl/km2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_pkg: shared types and codes for the 2-D k-means block
// Operation codes and configuration constants.
// ----------------------------------------------------------------------------
package km2d_pkg;
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SETC = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam int unsigned CFG_K     = 0;
  localparam int unsigned CFG_LIMIT = 1;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned RESULT_CAP = 8;
endpackage

>>> hdl/km2d_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_cell: one centroid cell of the distance chain
// Holds a centroid, compares its squared distance against the best so far
// carried in from the left, and hands the winning distance and index on.
// Accumulates member sums when a tagged point comes back on the return path.
// ----------------------------------------------------------------------------
module km2d_cell #(
  parameter int unsigned CW  = 16,
  parameter int unsigned IW  = 3,
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 26,
  parameter int unsigned NW  = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,        // cell in use
  // centroid write
  input  logic                 wr_en,
  input  logic signed [CW-1:0] wr_x,
  input  logic signed [CW-1:0] wr_y,
  // forward chain
  input  logic                 v_in,
  input  logic signed [CW-1:0] px_in,
  input  logic signed [CW-1:0] py_in,
  input  logic [2*CW+1:0]      bd_in,
  input  logic [IW-1:0]        bi_in,
  output logic                 v_out,
  output logic signed [CW-1:0] px_out,
  output logic signed [CW-1:0] py_out,
  output logic [2*CW+1:0]      bd_out,
  output logic [IW-1:0]        bi_out,
  // accumulate point tagged with its winner
  input  logic                 acc_clr,
  input  logic                 acc_v,
  input  logic [IW-1:0]        acc_i,
  input  logic signed [CW-1:0] acc_x,
  input  logic signed [CW-1:0] acc_y,
  output logic signed [SW-1:0] sum_x,
  output logic signed [SW-1:0] sum_y,
  output logic [NW-1:0]        tally,
  output logic signed [CW-1:0] cx,
  output logic signed [CW-1:0] cy
);
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [CW:0]   dx_r, dy_r;
  logic                 v1_r;
  logic signed [CW-1:0] px1_r, py1_r;
  logic [2*CW+1:0]      bd1_r;
  logic [IW-1:0]        bi1_r;
  logic [2*CW+1:0]      d_nxt;
  logic [CW-1:0]        ax, ay;
  logic [2*CW-1:0]      sqx, sqy;
  logic                 v_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [2*CW+1:0]      bd_r;
  logic [IW-1:0]        bi_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic [NW-1:0]        n_r;

  // magnitudes fit CW bits unsigned
  assign ax    = dx_r[CW] ? CW'(-dx_r) : dx_r[CW-1:0];
  assign ay    = dy_r[CW] ? CW'(-dy_r) : dy_r[CW-1:0];
  assign sqx   = (2*CW)'(ax) * (2*CW)'(ax);
  assign sqy   = (2*CW)'(ay) * (2*CW)'(ay);
  assign d_nxt = {2'b00, sqx} + {2'b00, sqy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      v1_r <= 1'b0;
      v_r  <= 1'b0;
      sx_r <= '0;
      sy_r <= '0;
      n_r  <= '0;
    end else begin
      if (wr_en) begin
        cx_r <= wr_x;
        cy_r <= wr_y;
      end
      v1_r <= v_in;
      v_r  <= v1_r;
      if (acc_clr) begin
        sx_r <= '0;
        sy_r <= '0;
        n_r  <= '0;
      end else if (acc_v && acc_i == IW'(IDX)) begin
        sx_r <= sx_r + SW'(acc_x);
        sy_r <= sy_r + SW'(acc_y);
        n_r  <= n_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= (CW+1)'(px_in) - (CW+1)'(cx_r);
    dy_r  <= (CW+1)'(py_in) - (CW+1)'(cy_r);
    px1_r <= px_in;
    py1_r <= py_in;
    bd1_r <= bd_in;
    bi1_r <= bi_in;
    px_r  <= px1_r;
    py_r  <= py1_r;
    if (en && (IDX == 0 || d_nxt < bd1_r)) begin
      bd_r <= d_nxt;
      bi_r <= IW'(IDX);
    end else begin
      bd_r <= bd1_r;
      bi_r <= bi1_r;
    end
  end

  assign v_out  = v_r;
  assign px_out = px_r;
  assign py_out = py_r;
  assign bd_out = bd_r;
  assign bi_out = bi_r;
  assign sum_x  = sx_r;
  assign sum_y  = sy_r;
  assign tally  = n_r;
  assign cx     = cx_r;
  assign cy     = cy_r;
endmodule

>>> hdl/km2d_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_div: signed restoring divider, one quotient bit per cycle
// Quotient truncates toward zero.
// ----------------------------------------------------------------------------
module km2d_div #(
  parameter int unsigned SW = 26,
  parameter int unsigned NW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [SW-1:0] num,
  input  logic [NW-1:0]        den,
  output logic                 done,
  output logic signed [SW-1:0] quo
);
  localparam int unsigned CNT_W = $clog2(SW + 1);
  logic [SW-1:0]    q_r;
  logic [NW:0]      rem_r;
  logic [NW-1:0]    d_r;
  logic             neg_r, busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW:0]      trial;
  logic [SW-1:0]    mag;

  assign mag   = num[SW-1] ? SW'(-num) : SW'(num);
  assign trial = {rem_r[NW-1:0], q_r[SW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= mag;
      rem_r <= '0;
      d_r   <= den;
      neg_r <= num[SW-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_r <= trial - {1'b0, d_r};
        q_r   <= {q_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[SW-2:0], 1'b0};
      end
    end
  end

  // an abandoned division never reports done once a new one starts
  assign done = done_r & ~go;
  assign quo  = neg_r ? SW'(-q_r) : SW'(q_r);
endmodule

>>> hdl/kmeans_2d_clustering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_2d_clustering: 2-D Lloyd k-means over a point store
// start/busy command port, one word per item. op LOAD appends a point
// (dropped when the store is full), op SETC writes a centroid slot, op RUN
// performs passes and then emits one result word per cluster in use, on
// out_valid for one cycle each, cluster 0 first, last_cluster on the final.
// LOAD and SETC leave busy low, so they stream at one per cycle. A RUN holds
// busy high for the whole run. Each pass streams the store through a chain of
// MAX_CLUSTERS centroid cells, one point a cycle, two register stages per cell.
// Each non-empty cluster in use then takes two serial divisions of SW-bit sums,
// SW = COORD_WIDTH + clog2(MAX_POINTS+1); an empty one keeps its centroid.
// The receiver cannot stall; results are not held.
// Reset clears point count, centroids and config (k = 2, limit = 8); the point
// memory is not cleared and needs no sweep.
// cfg_we writes register cfg_addr (0 clusters_in_use, 1 iteration_limit).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kmeans_2d_clustering #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_CLUSTERS = 8,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic [2:0]                    in_centroid_slot,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [km2d_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic [2:0]                    out_cluster_number,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic [10:0]                   out_member_count,
  output logic [7:0]                    out_passes_used,
  output logic                          out_last_cluster
);
  import km2d_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned PW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW  = $clog2(MAX_CLUSTERS);
  localparam int unsigned KW  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SW  = CW + PW;
  localparam int unsigned DW  = 2 * CW + 2;
  localparam int unsigned LAT = 2 * MAX_CLUSTERS + 1;
  localparam int unsigned DRW = $clog2(LAT + 2);
  localparam int unsigned KCAP = (MAX_CLUSTERS < RESULT_CAP) ? MAX_CLUSTERS : RESULT_CAP;

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_STREAM, S_DIV, S_WAIT, S_OUT} state_t;

  state_t               state_r;
  logic [3:0]           kreg_r;
  logic [7:0]           lim_r;
  logic [PW-1:0]        total_r;
  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic signed [CW-1:0] rd_x_r, rd_y_r;
  logic                 rd_v_r;
  logic [PW-1:0]        ptr_r;
  logic [DRW-1:0]       drain_r;
  logic [KW-1:0]        k_r;
  logic [7:0]           limit_r, passes_r;
  logic [IW-1:0]        c_r;
  logic                 coord_r, moved_r;
  logic signed [CW-1:0] newx_r;
  logic [IW:0]          oc_r;
  logic                 ov_r;
  logic [2:0]           ocn_r;
  logic signed [CW-1:0] ox_r, oy_r;
  logic [10:0]          on_r;
  logic                 olast_r;
  logic                 acc_clr;
  logic                 div_go, div_done;
  logic signed [SW-1:0] div_num, div_quo;
  logic [PW-1:0]        div_den;
  logic                 accept;
  logic [KW-1:0]        k_eff;

  logic                 cv   [MAX_CLUSTERS+1];
  logic signed [CW-1:0] cpx  [MAX_CLUSTERS+1];
  logic signed [CW-1:0] cpy  [MAX_CLUSTERS+1];
  logic [DW-1:0]        cbd  [MAX_CLUSTERS+1];
  logic [IW-1:0]        cbi  [MAX_CLUSTERS+1];
  logic signed [SW-1:0] sx   [MAX_CLUSTERS];
  logic signed [SW-1:0] sy   [MAX_CLUSTERS];
  logic [PW-1:0]        tl   [MAX_CLUSTERS];
  logic signed [CW-1:0] ccx  [MAX_CLUSTERS];
  logic signed [CW-1:0] ccy  [MAX_CLUSTERS];
  logic                 wr   [MAX_CLUSTERS];
  logic signed [CW-1:0] wx, wy;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    k_eff = (kreg_r == 4'd0) ? KW'(1) :
            ({1'b0, kreg_r} > 5'(KCAP)) ? KW'(KCAP) : KW'(kreg_r);
  end

  assign cv[0]  = rd_v_r;
  assign cpx[0] = rd_x_r;
  assign cpy[0] = rd_y_r;
  assign cbd[0] = '1;
  assign cbi[0] = '0;
  assign acc_clr = (state_r == S_CLR);

  always_comb begin
    wx = in_coord_x;
    wy = in_coord_y;
    if (state_r == S_DIV) begin
      wx = coord_r ? newx_r : ccx[c_r];
      wy = div_quo[CW-1:0];
    end
  end

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    assign wr[g] = (accept && in_op == OP_SETC && 32'(in_centroid_slot) == g) ||
                   (state_r == S_DIV && div_done && coord_r && c_r == IW'(g));
    km2d_cell #(.CW(CW), .IW(IW), .IDX(g), .SW(SW), .NW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (KW'(g) < k_r),
      .wr_en  (wr[g]),
      .wr_x   (wx),
      .wr_y   (wy),
      .v_in   (cv[g]),
      .px_in  (cpx[g]),
      .py_in  (cpy[g]),
      .bd_in  (cbd[g]),
      .bi_in  (cbi[g]),
      .v_out  (cv[g+1]),
      .px_out (cpx[g+1]),
      .py_out (cpy[g+1]),
      .bd_out (cbd[g+1]),
      .bi_out (cbi[g+1]),
      .acc_clr(acc_clr),
      .acc_v  (cv[MAX_CLUSTERS]),
      .acc_i  (cbi[MAX_CLUSTERS]),
      .acc_x  (cpx[MAX_CLUSTERS]),
      .acc_y  (cpy[MAX_CLUSTERS]),
      .sum_x  (sx[g]),
      .sum_y  (sy[g]),
      .tally  (tl[g]),
      .cx     (ccx[g]),
      .cy     (ccy[g])
    );
  end

  assign div_num = coord_r ? sy[c_r] : sx[c_r];
  assign div_den = tl[c_r];

  km2d_div #(.SW(SW), .NW(PW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD && total_r < PW'(MAX_POINTS)) begin
      mem_x[total_r[AW-1:0]] <= in_coord_x;
      mem_y[total_r[AW-1:0]] <= in_coord_y;
    end
    rd_x_r <= mem_x[ptr_r[AW-1:0]];
    rd_y_r <= mem_y[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kreg_r   <= 4'd2;
      lim_r    <= 8'd8;
      total_r  <= '0;
      rd_v_r   <= 1'b0;
      ptr_r    <= '0;
      drain_r  <= '0;
      k_r      <= '0;
      limit_r  <= '0;
      passes_r <= '0;
      c_r      <= '0;
      coord_r  <= 1'b0;
      moved_r  <= 1'b0;
      oc_r     <= '0;
      ov_r     <= 1'b0;
      div_go   <= 1'b0;
      ocn_r    <= '0;
      olast_r  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      ov_r   <= 1'b0;
      rd_v_r <= 1'b0;
      if (cfg_we) begin
        if (32'(cfg_addr) == CFG_K) kreg_r <= cfg_wdata[3:0];
        else lim_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(in_op))
              OP_LOAD: if (total_r < PW'(MAX_POINTS)) total_r <= total_r + 1'b1;
              OP_RUN: begin
                k_r      <= k_eff;
                limit_r  <= (lim_r == 8'd0) ? 8'd1 : lim_r;
                passes_r <= '0;
                state_r  <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          ptr_r   <= '0;
          drain_r <= '0;
          moved_r <= 1'b0;
          state_r <= S_STREAM;
        end
        S_STREAM: begin
          if (ptr_r < total_r) begin
            rd_v_r <= 1'b1;
            ptr_r  <= ptr_r + 1'b1;
          end else if (drain_r == DRW'(LAT + 1)) begin
            c_r     <= '0;
            coord_r <= 1'b0;
            state_r <= S_DIV;
            div_go  <= 1'b1;
            passes_r <= passes_r + 1'b1;
          end else begin
            drain_r <= drain_r + 1'b1;
          end
        end
        S_DIV: begin
          if (tl[c_r] == '0) begin
            div_go <= 1'b0;
            state_r <= S_WAIT;
          end else if (div_done) begin
            if (!coord_r) begin
              newx_r  <= div_quo[CW-1:0];
              coord_r <= 1'b1;
              div_go  <= 1'b1;
            end else begin
              if (newx_r != ccx[c_r] || div_quo[CW-1:0] != ccy[c_r]) moved_r <= 1'b1;
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (KW'(c_r) + 1'b1 < k_r) begin
            c_r     <= c_r + 1'b1;
            coord_r <= 1'b0;
            div_go  <= 1'b1;
            state_r <= S_DIV;
          end else if (moved_r && passes_r < limit_r) begin
            state_r <= S_CLR;
          end else begin
            oc_r    <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          ov_r    <= 1'b1;
          ocn_r   <= 3'(oc_r);
          ox_r    <= ccx[oc_r[IW-1:0]];
          oy_r    <= ccy[oc_r[IW-1:0]];
          on_r    <= 11'(tl[oc_r[IW-1:0]]);
          olast_r <= (KW'(oc_r) + 1'b1 == k_r);
          oc_r    <= oc_r + 1'b1;
          if (KW'(oc_r) + 1'b1 == k_r) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_cluster_number = ocn_r;
  assign out_center_x       = ox_r;
  assign out_center_y       = oy_r;
  assign out_member_count   = on_r;
  assign out_passes_used    = passes_r;
  assign out_last_cluster   = olast_r;

  `ASSERT_NEVER(a_total_cap, clk, rst_n, total_r > PW'(MAX_POINTS))
  `ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid && !out_last_cluster |-> busy)
  `ASSERT_IMPL(a_last_idle, clk, rst_n, out_valid && out_last_cluster |-> !busy)
  `ASSERT_IMPL(a_pass_lim, clk, rst_n, state_r == S_OUT |-> passes_r <= limit_r)
endmodule
